// ----- hw/rtl/cap_pkg.sv -----
// ----------------------------------------------------------------------------
// cap_pkg
// Shared widths, register codes, angle constants, arctangent table and
// control types of the circular arc point generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cap_pkg;

    localparam int IDX_W      = 16;
    localparam int CNT_W      = 17;
    localparam int QUO_W      = 32;
    localparam int PROD_W     = QUO_W + IDX_W;
    localparam int XY_W       = 33;
    localparam int Z_W        = 34;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ARC_RADIUS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Z_OFFSET    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_END_ANGLE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd7;

    localparam logic [34:0]            FOUR_PI_Q30 = 35'd13493037704;
    localparam logic [33:0]            TWO_PI_Q30  = 34'd6746518852;
    localparam logic signed [Z_W-1:0]  PI_Q30      = 34'sd3373259426;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [XY_W-1:0] GAIN_Q30    = 33'sd652032874;
    localparam logic signed [63:0]     ROUND_Q30   = 64'sd536870912;

    localparam logic [31:0] ATAN_Q30 [0:31] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
        32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic valid;
        logic oor;
        logic flip;
    } cap_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -35'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cap_div_cell.sv -----
// ----------------------------------------------------------------------------
// cap_div_cell
// One restoring division cell: one quotient bit per cell, partial remainder
// and shifting dividend/quotient word handed to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cap_div_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [cap_pkg::CNT_W-1:0]   divisor,
    input  cap_pkg::cap_ctl_t           ctl_in,
    input  logic [cap_pkg::CNT_W-1:0]   rem_in,
    input  logic [cap_pkg::QUO_W-1:0]   word_in,
    output cap_pkg::cap_ctl_t           ctl_out,
    output logic [cap_pkg::CNT_W-1:0]   rem_out,
    output logic [cap_pkg::QUO_W-1:0]   word_out
);

    logic [cap_pkg::CNT_W+1:0] trial;
    logic                      fits;
    logic [cap_pkg::CNT_W-1:0] rem_next;
    logic [cap_pkg::QUO_W-1:0] word_next;
    cap_pkg::cap_ctl_t         ctl_reg;
    logic [cap_pkg::CNT_W-1:0] rem_reg;
    logic [cap_pkg::QUO_W-1:0] word_reg;

    assign trial = {1'b0, rem_in, word_in[cap_pkg::QUO_W-1]} - {2'b00, divisor};
    assign fits  = ~trial[cap_pkg::CNT_W+1];

    always_comb
    begin
        if (fits)
        begin
            rem_next = trial[cap_pkg::CNT_W-1:0];
        end
        else
        begin
            rem_next = {rem_in[cap_pkg::CNT_W-2:0], word_in[cap_pkg::QUO_W-1]};
        end
        word_next = {word_in[cap_pkg::QUO_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            word_reg <= word_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign rem_out  = rem_reg;
    assign word_out = word_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/cap_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// cap_cordic_cell
// One CORDIC rotation cell: shift-add rotation of x/y and arctangent update
// of the residual angle, registered towards the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cap_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  cap_pkg::cap_ctl_t                  ctl_in,
    input  logic signed [cap_pkg::XY_W-1:0]    x_in,
    input  logic signed [cap_pkg::XY_W-1:0]    y_in,
    input  logic signed [cap_pkg::Z_W-1:0]     z_in,
    output cap_pkg::cap_ctl_t                  ctl_out,
    output logic signed [cap_pkg::XY_W-1:0]    x_out,
    output logic signed [cap_pkg::XY_W-1:0]    y_out,
    output logic signed [cap_pkg::Z_W-1:0]     z_out
);

    logic signed [cap_pkg::XY_W-1:0] x_sh;
    logic signed [cap_pkg::XY_W-1:0] y_sh;
    logic signed [cap_pkg::Z_W-1:0]  atan_step;
    logic signed [cap_pkg::XY_W-1:0] x_next;
    logic signed [cap_pkg::XY_W-1:0] y_next;
    logic signed [cap_pkg::Z_W-1:0]  z_next;
    cap_pkg::cap_ctl_t               ctl_reg;
    logic signed [cap_pkg::XY_W-1:0] x_reg;
    logic signed [cap_pkg::XY_W-1:0] y_reg;
    logic signed [cap_pkg::Z_W-1:0]  z_reg;

    assign x_sh      = x_in >>> STAGE;
    assign y_sh      = y_in >>> STAGE;
    assign atan_step = $signed({2'b00, cap_pkg::ATAN_Q30[STAGE]});

    always_comb
    begin
        if (!z_in[cap_pkg::Z_W-1])
        begin
            x_next = x_in - y_sh;
            y_next = y_in + x_sh;
            z_next = z_in - atan_step;
        end
        else
        begin
            x_next = x_in + y_sh;
            y_next = y_in - x_sh;
            z_next = z_in + atan_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/circular_arc_point_generator_unit.sv -----
// ----------------------------------------------------------------------------
// circular_arc_point_generator_unit
// Arc point generator: angle interpolation, range reduction, CORDIC
// sine/cosine and saturated placement around the circle centre.
// ----------------------------------------------------------------------------
// One point request is taken every cycle unless req_stall is high. A result
// passes the index product registers, 32 divider cells (one quotient bit each),
// the angle wrap and fold registers, the CORDIC cells, then scaling by the
// radius, rounding and the output register. The whole pipeline holds while a
// result waits on rsp_stall and the stage in front of the output register is
// full.
`default_nettype none

module circular_arc_point_generator_unit #(
    parameter int MAX_POINTS    = 65536,
    parameter int CORDIC_STAGES = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [cap_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cap_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic [cap_pkg::IDX_W-1:0]            point_index,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output logic signed [31:0]                   pos_x,
    output logic signed [31:0]                   pos_y,
    output logic signed [31:0]                   pos_z,
    output logic                                 out_of_range
);

    localparam int QW = cap_pkg::QUO_W;
    localparam int CS = CORDIC_STAGES;

    logic signed [31:0]               center_x_reg;
    logic signed [31:0]               center_y_reg;
    logic signed [31:0]               center_z_reg;
    logic [30:0]                      arc_radius_reg;
    logic signed [31:0]               z_offset_reg;
    logic signed [31:0]               start_angle_reg;
    logic signed [31:0]               end_angle_reg;
    logic [cap_pkg::CNT_W-1:0]        point_count_reg;

    logic [cap_pkg::CNT_W-1:0]        count_eff;
    logic signed [32:0]               angle_diff;
    logic                             diff_neg;
    logic [31:0]                      abs_diff;
    logic                             in_oor;

    logic                             out_en;
    logic                             pipe_en;

    cap_pkg::cap_ctl_t                s1_ctl_reg;
    logic [cap_pkg::IDX_W-1:0]        s1_idx_reg;
    logic [31:0]                      s1_absdiff_reg;
    cap_pkg::cap_ctl_t                s2_ctl_reg;
    logic [cap_pkg::PROD_W-1:0]       s2_prod_reg;
    logic [cap_pkg::PROD_W-1:0]       s2_prod_next;

    cap_pkg::cap_ctl_t                div_ctl  [0:QW];
    logic [cap_pkg::CNT_W-1:0]        div_rem  [0:QW];
    logic [QW-1:0]                    div_word [0:QW];

    cap_pkg::cap_ctl_t                a_ctl_reg;
    logic signed [31:0]               a_ang_reg;
    logic signed [31:0]               a_ang_next;
    cap_pkg::cap_ctl_t                b_ctl_reg;
    logic [34:0]                      b_z_reg;
    logic [34:0]                      b_z_next;
    cap_pkg::cap_ctl_t                c_ctl_reg;
    logic [33:0]                      c_z_reg;
    logic [33:0]                      c_z_next;
    cap_pkg::cap_ctl_t                d_ctl_reg;
    logic [32:0]                      d_z_reg;
    logic [32:0]                      d_z_next;
    cap_pkg::cap_ctl_t                e_ctl_reg;
    logic signed [cap_pkg::Z_W-1:0]   e_z_reg;
    logic signed [cap_pkg::Z_W-1:0]   e_z_next;
    logic signed [cap_pkg::Z_W-1:0]   d_z_signed;
    cap_pkg::cap_ctl_t                f_ctl_reg;
    cap_pkg::cap_ctl_t                f_ctl_next;
    logic signed [cap_pkg::Z_W-1:0]   f_z_reg;
    logic signed [cap_pkg::Z_W-1:0]   f_z_next;

    cap_pkg::cap_ctl_t                cor_ctl [0:CS];
    logic signed [cap_pkg::XY_W-1:0]  cor_x   [0:CS];
    logic signed [cap_pkg::XY_W-1:0]  cor_y   [0:CS];
    logic signed [cap_pkg::Z_W-1:0]   cor_z   [0:CS];

    cap_pkg::cap_ctl_t                n_ctl_reg;
    logic signed [cap_pkg::XY_W-1:0]  n_c_reg;
    logic signed [cap_pkg::XY_W-1:0]  n_s_reg;
    cap_pkg::cap_ctl_t                m_ctl_reg;
    logic signed [63:0]               m_px_reg;
    logic signed [63:0]               m_py_reg;
    logic signed [31:0]               radius_s;
    logic signed [63:0]               px_round;
    logic signed [63:0]               py_round;
    cap_pkg::cap_ctl_t                o1_ctl_reg;
    logic signed [33:0]               o1_dx_reg;
    logic signed [33:0]               o1_dy_reg;

    logic                             rsp_valid_reg;
    logic                             oor_reg;
    logic signed [31:0]               pos_x_reg;
    logic signed [31:0]               pos_y_reg;
    logic signed [31:0]               pos_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            center_z_reg    <= '0;
            arc_radius_reg  <= '0;
            z_offset_reg    <= '0;
            start_angle_reg <= '0;
            end_angle_reg   <= '0;
            point_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cap_pkg::REG_CENTER_X:    center_x_reg    <= $signed(cfg_data);
                cap_pkg::REG_CENTER_Y:    center_y_reg    <= $signed(cfg_data);
                cap_pkg::REG_CENTER_Z:    center_z_reg    <= $signed(cfg_data);
                cap_pkg::REG_ARC_RADIUS:  arc_radius_reg  <= cfg_data[30:0];
                cap_pkg::REG_Z_OFFSET:    z_offset_reg    <= $signed(cfg_data);
                cap_pkg::REG_START_ANGLE: start_angle_reg <= $signed(cfg_data);
                cap_pkg::REG_END_ANGLE:   end_angle_reg   <= $signed(cfg_data);
                cap_pkg::REG_POINT_COUNT: point_count_reg <= cfg_data[cap_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign count_eff  = ({15'd0, point_count_reg} > 32'(MAX_POINTS)) ?
                        cap_pkg::CNT_W'(MAX_POINTS) : point_count_reg;
    assign angle_diff = 33'(end_angle_reg) - 33'(start_angle_reg);
    assign diff_neg   = angle_diff[32];
    assign abs_diff   = diff_neg ? 32'(-angle_diff) : angle_diff[31:0];
    assign in_oor     = ({1'b0, point_index} >= count_eff);

    // hold everything only when the output is held and the last stage is full
    assign out_en    = ~rsp_valid_reg | ~rsp_stall;
    assign pipe_en   = out_en | ~o1_ctl_reg.valid;
    assign req_stall = ~pipe_en;

    assign s2_prod_next = cap_pkg::PROD_W'(s1_absdiff_reg) * cap_pkg::PROD_W'(s1_idx_reg);

    assign div_ctl[0]  = s2_ctl_reg;
    assign div_rem[0]  = cap_pkg::CNT_W'(s2_prod_reg[cap_pkg::PROD_W-1:QW]);
    assign div_word[0] = s2_prod_reg[QW-1:0];

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        cap_div_cell u_div_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (pipe_en),
            .divisor  (count_eff),
            .ctl_in   (div_ctl[k]),
            .rem_in   (div_rem[k]),
            .word_in  (div_word[k]),
            .ctl_out  (div_ctl[k+1]),
            .rem_out  (div_rem[k+1]),
            .word_out (div_word[k+1])
        );
    end

    assign a_ang_next = div_ctl[QW].flip ? start_angle_reg - $signed(div_word[QW]) :
                                           start_angle_reg + $signed(div_word[QW]);
    assign b_z_next   = {a_ang_reg[31], a_ang_reg, 2'b00} + cap_pkg::FOUR_PI_Q30;
    assign c_z_next   = (b_z_reg >= cap_pkg::FOUR_PI_Q30) ?
                        34'(b_z_reg - cap_pkg::FOUR_PI_Q30) : b_z_reg[33:0];
    assign d_z_next   = (c_z_reg >= cap_pkg::TWO_PI_Q30) ?
                        33'(c_z_reg - cap_pkg::TWO_PI_Q30) : c_z_reg[32:0];
    assign d_z_signed = $signed({1'b0, d_z_reg});
    assign e_z_next   = (d_z_signed > cap_pkg::PI_Q30) ?
                        d_z_signed - $signed(cap_pkg::TWO_PI_Q30) : d_z_signed;

    always_comb
    begin
        f_ctl_next = e_ctl_reg;
        if (e_z_reg > cap_pkg::HALF_PI_Q30)
        begin
            f_z_next        = e_z_reg - cap_pkg::PI_Q30;
            f_ctl_next.flip = 1'b1;
        end
        else if (e_z_reg < -cap_pkg::HALF_PI_Q30)
        begin
            f_z_next        = e_z_reg + cap_pkg::PI_Q30;
            f_ctl_next.flip = 1'b1;
        end
        else
        begin
            f_z_next        = e_z_reg;
            f_ctl_next.flip = 1'b0;
        end
    end

    assign cor_ctl[0] = f_ctl_reg;
    assign cor_x[0]   = cap_pkg::GAIN_Q30;
    assign cor_y[0]   = '0;
    assign cor_z[0]   = f_z_reg;

    for (genvar k = 0; k < CS; k++)
    begin : g_cordic
        cap_cordic_cell #(
            .STAGE (k)
        ) u_cordic_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (pipe_en),
            .ctl_in  (cor_ctl[k]),
            .x_in    (cor_x[k]),
            .y_in    (cor_y[k]),
            .z_in    (cor_z[k]),
            .ctl_out (cor_ctl[k+1]),
            .x_out   (cor_x[k+1]),
            .y_out   (cor_y[k+1]),
            .z_out   (cor_z[k+1])
        );
    end

    assign radius_s = $signed({1'b0, arc_radius_reg});
    assign px_round = m_px_reg + cap_pkg::ROUND_Q30;
    assign py_round = m_py_reg + cap_pkg::ROUND_Q30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            a_ctl_reg  <= '0;
            b_ctl_reg  <= '0;
            c_ctl_reg  <= '0;
            d_ctl_reg  <= '0;
            e_ctl_reg  <= '0;
            f_ctl_reg  <= '0;
            n_ctl_reg  <= '0;
            m_ctl_reg  <= '0;
            o1_ctl_reg <= '0;
        end
        else if (pipe_en)
        begin
            s1_ctl_reg <= cap_pkg::cap_ctl_t'{valid: req_valid, oor: in_oor, flip: diff_neg};
            s2_ctl_reg <= s1_ctl_reg;
            a_ctl_reg  <= div_ctl[QW];
            b_ctl_reg  <= a_ctl_reg;
            c_ctl_reg  <= b_ctl_reg;
            d_ctl_reg  <= c_ctl_reg;
            e_ctl_reg  <= d_ctl_reg;
            f_ctl_reg  <= f_ctl_next;
            n_ctl_reg  <= cor_ctl[CS];
            m_ctl_reg  <= n_ctl_reg;
            o1_ctl_reg <= m_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_idx_reg     <= point_index;
            s1_absdiff_reg <= abs_diff;
            s2_prod_reg    <= s2_prod_next;
            a_ang_reg      <= a_ang_next;
            b_z_reg        <= b_z_next;
            c_z_reg        <= c_z_next;
            d_z_reg        <= d_z_next;
            e_z_reg        <= e_z_next;
            f_z_reg        <= f_z_next;
            n_c_reg        <= cor_ctl[CS].flip ? -cor_x[CS] : cor_x[CS];
            n_s_reg        <= cor_ctl[CS].flip ? -cor_y[CS] : cor_y[CS];
            m_px_reg       <= radius_s * n_c_reg;
            m_py_reg       <= radius_s * n_s_reg;
            o1_dx_reg      <= px_round[63:30];
            o1_dy_reg      <= py_round[63:30];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            rsp_valid_reg <= o1_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            oor_reg <= o1_ctl_reg.oor;
            if (o1_ctl_reg.oor)
            begin
                pos_x_reg <= '0;
                pos_y_reg <= '0;
                pos_z_reg <= '0;
            end
            else
            begin
                pos_x_reg <= cap_pkg::sat32(35'(center_x_reg) + 35'(o1_dx_reg));
                pos_y_reg <= cap_pkg::sat32(35'(center_y_reg) + 35'(o1_dy_reg));
                pos_z_reg <= cap_pkg::sat32(35'(center_z_reg) + 35'(z_offset_reg));
            end
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign out_of_range = oor_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign pos_z        = pos_z_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/cap_checker.sv -----
// ----------------------------------------------------------------------------
// cap_checker
// Port-level checks of the arc point generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cap_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [31:0] pos_x,
    input logic [31:0] pos_y,
    input logic [31:0] pos_z,
    input logic        out_of_range
);

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && out_of_range |-> pos_x == 32'd0 && pos_y == 32'd0 && pos_z == 32'd0)
        else $error("out-of-range result with non-zero coordinates");

    a_req_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!rsp_valid || !rsp_stall) |-> !req_stall)
        else $error("request stalled while the output side is free");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped before its transfer");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(pos_x) && $stable(pos_y) && $stable(pos_z)
                                   && $stable(out_of_range))
        else $error("stalled result changed");

endmodule

bind circular_arc_point_generator_unit cap_checker u_cap_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_stall    (req_stall),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .out_of_range (out_of_range)
);

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for circular_arc_point_generator_unit. A short table of
// probe points under fixed register settings comes first, followed by random
// settings and random point requests. Every result is compared field by field
// against a cycle-free model of the interpolation, CORDIC and saturation.
// ----------------------------------------------------------------------------
module tb;

    localparam int  MAX_POINTS    = 65536;
    localparam int  CORDIC_STAGES = 24;
    localparam int  ITEMS         = 650;
    localparam int  SETTLE        = CORDIC_STAGES + 60;
    localparam int  LIMIT         = 200000;

    localparam longint TWO_PI  = longint'(cap_pkg::TWO_PI_Q30);
    localparam longint PI      = longint'(cap_pkg::PI_Q30);
    localparam longint HALF_PI = longint'(cap_pkg::HALF_PI_Q30);
    localparam longint GAIN    = longint'(cap_pkg::GAIN_Q30);
    localparam longint ROUNDING = longint'(cap_pkg::ROUND_Q30);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               oor;
    } arc_point_t;

    typedef struct {
        int          setting;
        logic [15:0] idx;
        bit          typed;
        arc_point_t  want;
    } probe_row_t;

    localparam arc_point_t FLAGGED = '{32'sh0, 32'sh0, 32'sh0, 1'b1};
    localparam arc_point_t NONE    = '{32'sh0, 32'sh0, 32'sh0, 1'b0};

    localparam logic [cap_pkg::CFG_IDX_W-1:0] REG_ORDER [0:7] = '{
        cap_pkg::REG_CENTER_X, cap_pkg::REG_CENTER_Y, cap_pkg::REG_CENTER_Z,
        cap_pkg::REG_ARC_RADIUS, cap_pkg::REG_Z_OFFSET, cap_pkg::REG_START_ANGLE,
        cap_pkg::REG_END_ANGLE, cap_pkg::REG_POINT_COUNT
    };

    logic [31:0] probe_settings [0:4][0:7] = '{
        '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0, 32'd843314857, 32'd4},
        '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
          32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h00010000},
        '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
          32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h0001FFFF},
        '{32'h00123456, 32'hFFEDCBA9, 32'h00001000, 32'h0,
          32'hFFFFF000, 32'h10000000, 32'hF0000000, 32'd1}
    };

    probe_row_t probes [0:19] = '{
        '{0, 16'd0,     1'b1, FLAGGED},
        '{0, 16'hFFFF,  1'b1, FLAGGED},
        '{1, 16'd0,     1'b0, NONE},
        '{1, 16'd1,     1'b0, NONE},
        '{1, 16'd2,     1'b0, NONE},
        '{1, 16'd3,     1'b0, NONE},
        '{1, 16'd4,     1'b1, FLAGGED},
        '{1, 16'hFFFF,  1'b1, FLAGGED},
        '{1, 16'h5555,  1'b1, FLAGGED},
        '{1, 16'hAAAA,  1'b1, FLAGGED},
        '{2, 16'd0,     1'b0, NONE},
        '{2, 16'd1,     1'b0, NONE},
        '{2, 16'h8000,  1'b0, NONE},
        '{2, 16'hFFFF,  1'b0, NONE},
        '{2, 16'h5555,  1'b0, NONE},
        '{3, 16'd0,     1'b0, NONE},
        '{3, 16'hFFFF,  1'b0, NONE},
        '{3, 16'd12345, 1'b0, NONE},
        '{4, 16'd0,     1'b1, '{32'sh00123456, 32'shFFEDCBA9, 32'sh0, 1'b0}},
        '{4, 16'd1,     1'b1, FLAGGED}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        req_valid;
    logic        req_stall;
    logic [15:0] point_index;
    logic        rsp_valid;
    logic        rsp_stall;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        out_of_range;

    logic [31:0] centre_x, centre_y, centre_z, lift, angle_from, angle_to;
    logic [30:0] radius;
    logic [16:0] count;

    arc_point_t  pending_points [$];
    bit          idling;
    int          stall_left;
    int          sent;
    int          received;
    int          flagged;
    int          clipped;
    int          settings_used;
    int          errors;
    int          cycles;

    circular_arc_point_generator_unit #(
        .MAX_POINTS    (MAX_POINTS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .point_index  (point_index),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .out_of_range (out_of_range)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic longint clamp_q16(input longint v);
        longint r;
        r = v;
        if (v > 64'sd2147483647)
        begin
            r = 64'sd2147483647;
        end
        else if (v < -64'sd2147483648)
        begin
            r = -64'sd2147483648;
        end
        return r;
    endfunction

    function automatic longint effective_count();
        longint n;
        n = longint'(count);
        if (n > MAX_POINTS)
        begin
            n = MAX_POINTS;
        end
        return n;
    endfunction

    function automatic arc_point_t arc_point(input logic [15:0] idx);
        longint     n;
        longint     st;
        longint     ang;
        longint     z;
        longint     x;
        longint     y;
        longint     xs;
        longint     ys;
        longint     r;
        bit         flip;
        arc_point_t p;
        n = effective_count();
        p = FLAGGED;
        if (longint'(idx) < n)
        begin
            st   = longint'(signed'(angle_from));
            ang  = st + ((longint'(signed'(angle_to)) - st) * longint'(idx)) / n;
            z    = (ang * 4) % TWO_PI;
            flip = 1'b0;
            if (z < 0)
            begin
                z = z + TWO_PI;
            end
            if (z > PI)
            begin
                z = z - TWO_PI;
            end
            if (z > HALF_PI)
            begin
                z    = z - PI;
                flip = 1'b1;
            end
            else if (z < -HALF_PI)
            begin
                z    = z + PI;
                flip = 1'b1;
            end
            x = GAIN;
            y = 0;
            for (int k = 0; k < CORDIC_STAGES && k < 32; k++)
            begin
                xs = x >>> k;
                ys = y >>> k;
                if (z >= 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(cap_pkg::ATAN_Q30[k]);
                end
                else
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(cap_pkg::ATAN_Q30[k]);
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            r     = longint'(radius);
            p.x   = 32'(clamp_q16(longint'(signed'(centre_x)) + ((r * x + ROUNDING) >>> 30)));
            p.y   = 32'(clamp_q16(longint'(signed'(centre_y)) + ((r * y + ROUNDING) >>> 30)));
            p.z   = 32'(clamp_q16(longint'(signed'(centre_z)) + longint'(signed'(lift))));
            p.oor = 1'b0;
        end
        return p;
    endfunction

    task automatic write_reg(input logic [2:0] code, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= code;
        cfg_data  <= data;
        @(posedge clk);
        case (code)
            cap_pkg::REG_CENTER_X:    centre_x   = data;
            cap_pkg::REG_CENTER_Y:    centre_y   = data;
            cap_pkg::REG_CENTER_Z:    centre_z   = data;
            cap_pkg::REG_ARC_RADIUS:  radius     = data[30:0];
            cap_pkg::REG_Z_OFFSET:    lift       = data;
            cap_pkg::REG_START_ANGLE: angle_from = data;
            cap_pkg::REG_END_ANGLE:   angle_to   = data;
            cap_pkg::REG_POINT_COUNT: count      = data[16:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(input logic [31:0] vals [0:7]);
        for (int k = 0; k < 8; k++)
        begin
            write_reg(REG_ORDER[k], vals[k]);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // hold the payload until the transfer, then log what should come back
    task automatic send_point(input logic [15:0] idx, input arc_point_t want);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_valid   <= 1'b1;
        point_index <= idx;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        pending_points.insert(pending_points.size(), want);
        sent++;
    endtask

    function automatic logic [31:0] random_word();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h0;
                    1:       v = 32'h7FFFFFFF;
                    2:       v = 32'h80000000;
                    default: v = 32'hFFFFFFFF;
                endcase
            end
            1:
            begin
                v = $urandom();
            end
            default:
            begin
                v = $urandom_range(0, 32'h01FFFFFF);
                if ($urandom_range(0, 1) == 1)
                begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] random_count();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 7))
            0:       v[16:0] = 17'd0;
            1:       v[16:0] = 17'h10000 | 17'($urandom_range(0, 65535));
            2:       v[16:0] = v[16:0];
            default: v[16:0] = 17'($urandom_range(1, 300));
        endcase
        return v;
    endfunction

    function automatic logic [15:0] random_index();
        longint      n;
        logic [15:0] idx;
        n   = effective_count();
        idx = 16'($urandom());
        case ($urandom_range(0, 9))
            0:
            begin
                if (n <= 65535)
                begin
                    idx = 16'(n);
                end
            end
            1:
            begin
                idx = 16'($urandom());
            end
            default:
            begin
                if (n > 0)
                begin
                    idx = 16'($urandom_range(0, int'(n - 1)));
                end
            end
        endcase
        return idx;
    endfunction

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h got %h", $time, field, want, got);
            errors++;
        end
    endtask

    // drain results; while idling is set, stall in bursts of random length
    always @(posedge clk)
    begin : result_check
        arc_point_t want;
        if (rst_n)
        begin
            if (rsp_valid === 1'b1 && rsp_stall == 1'b0)
            begin
                received++;
                if (pending_points.size() == 0)
                begin
                    $display("%0t: unexpected result expected none got %h %h %h %b",
                             $time, pos_x, pos_y, pos_z, out_of_range);
                    errors++;
                end
                else
                begin
                    want = pending_points.pop_front();
                    report("pos_x", want.x, pos_x);
                    report("pos_y", want.y, pos_y);
                    report("pos_z", want.z, pos_z);
                    report("out_of_range", {31'd0, want.oor}, {31'd0, out_of_range});
                    if (out_of_range === 1'b1)
                    begin
                        flagged++;
                    end
                    if (pos_x == 32'sh7FFFFFFF || pos_x == 32'sh80000000 ||
                        pos_y == 32'sh7FFFFFFF || pos_y == 32'sh80000000 ||
                        pos_z == 32'sh7FFFFFFF || pos_z == 32'sh80000000)
                    begin
                        clipped++;
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                rsp_stall  <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [31:0] vals [0:7];
        arc_point_t  want;
        logic [15:0] idx;
        int          current;
        int          run_len;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        req_valid     = 1'b0;
        point_index   = '0;
        rsp_stall     = 1'b0;
        centre_x      = '0;
        centre_y      = '0;
        centre_z      = '0;
        radius        = '0;
        lift          = '0;
        angle_from    = '0;
        angle_to      = '0;
        count         = '0;
        idling        = 1'b1;
        stall_left    = 0;
        sent          = 0;
        received      = 0;
        flagged       = 0;
        clipped       = 0;
        settings_used = 0;
        errors        = 0;
        cycles        = 0;
        current       = -1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[k])
        begin
            if (probes[k].setting != current)
            begin
                req_valid <= 1'b0;
                wait_drained();
                current = probes[k].setting;
                load_setting(probe_settings[current]);
            end
            want = probes[k].typed ? probes[k].want : arc_point(probes[k].idx);
            send_point(probes[k].idx, want);
        end

        while (sent < ITEMS)
        begin
            req_valid <= 1'b0;
            wait_drained();
            idling = (sent < ITEMS - 100) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < 8; k++)
            begin
                vals[k] = random_word();
            end
            vals[7] = random_count();
            load_setting(vals);
            run_len = $urandom_range(40, 90);
            for (int k = 0; k < run_len && sent < ITEMS; k++)
            begin
                idx  = random_index();
                want = arc_point(idx);
                send_point(idx, want);
            end
        end

        req_valid <= 1'b0;
        idling = 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d point requests under %0d register settings; %0d results checked.",
                 sent, settings_used, received);
        $display("%0d results flagged out of range, %0d with a clipped coordinate.",
                 flagged, clipped);
        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
